// ===== hdl/fcr_pkg.sv =====
// Shared types and constants for the framed command receiver.
// Used by every design module of the block; depends on nothing.
package fcr_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_SET_ALL = 2'd1;
    localparam logic [1:0] CFG_ACK     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] MAGIC_RESET   = 8'hAA;
    localparam logic [7:0] SET_ALL_RESET = 8'h00;
    localparam logic [7:0] ACK_RESET     = 8'h00;

    // Checksum mask and position ceiling
    localparam logic [7:0] CHECK_MASK = 8'h7F;
    localparam logic [8:0] POS_MAX    = 9'd511;

    // Ack queue depth
    localparam int QUEUE_DEPTH = 2;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DATA
    } phase_t;

    // Position of the byte being sent within an acknowledge
    typedef enum logic [1:0] {
        SLOT_MAGIC,
        SLOT_CODE,
        SLOT_ZERO
    } ack_slot_t;

    // One accepted frame waiting to be acknowledged
    typedef struct packed {
        logic [7:0] command;
        logic       set_all;
    } ack_req_t;

    // Queue fill status seen by the top level and by back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/fcr_front.sv =====
// Front end: parses received bytes into frames and posts an ack request
// for every accepted frame. Depends on fcr_pkg.
module fcr_front
    import fcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       powered,
    input  logic [7:0] magic_byte,
    input  logic [7:0] set_all_code,
    output logic       push,
    output ack_req_t   push_req
);

    phase_t     phase_reg, phase_next;
    logic [8:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] xor_reg, xor_next;

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            cmd_reg   <= '0;
            xor_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            xor_reg   <= xor_next;
        end
    end

    // Advance the parser by one byte; a magic byte always restarts the frame
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        xor_next   = xor_reg;
        push       = 1'b0;
        if (accept && powered) begin
            if (rx_byte == magic_byte) begin
                phase_next = PH_HEADER;
                pos_next   = 9'd1;
                xor_next   = '0;
            end else begin
                case (phase_reg)
                    PH_HEADER: begin
                        if (pos_reg == 9'd1) begin
                            cmd_next = rx_byte;
                            pos_next = 9'd2;
                        end else begin
                            len_next = rx_byte;
                            if (rx_byte == 8'd0) begin
                                push       = 1'b1;
                                phase_next = PH_IDLE;
                                pos_next   = '0;
                            end else begin
                                phase_next = PH_DATA;
                                pos_next   = 9'd3;
                                xor_next   = '0;
                            end
                        end
                    end
                    PH_DATA: begin
                        if ({1'b0, pos_reg} < ({2'b00, len_reg} + 10'd2)) begin
                            xor_next = xor_reg ^ rx_byte;
                            if (pos_reg < POS_MAX) begin
                                pos_next = pos_reg + 9'd1;
                            end
                        end else begin
                            // Checksum byte: accept on match, drop otherwise
                            push       = ((xor_reg & CHECK_MASK) == rx_byte);
                            phase_next = PH_IDLE;
                            pos_next   = '0;
                        end
                    end
                    default: begin
                        // Idle: drop non-magic bytes
                    end
                endcase
            end
        end
    end

    assign push_req.command = cmd_reg;
    assign push_req.set_all = (cmd_reg == set_all_code);

endmodule

// ===== hdl/fcr_queue.sv =====
// Short queue of ack requests between the parser and the ack sender.
// Depends on fcr_pkg.
module fcr_queue
    import fcr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  ack_req_t  push_req,
    input  logic      pop,
    output ack_req_t  head_req,
    output q_status_t status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    ack_req_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign head_req     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== hdl/fcr_back.sv =====
// Back end: sends the three acknowledge bytes for each queued request.
// Depends on fcr_pkg.
module fcr_back
    import fcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ack_req_t   head_req,
    input  q_status_t  q_status,
    output logic       pop,
    input  logic [7:0] magic_byte,
    input  logic [7:0] ack_code,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [15:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    ack_slot_t slot_reg, slot_next;
    logic      valid_reg, valid_next;
    ack_req_t  req_reg, req_next;
    logic      load;
    logic [7:0] tx_byte;

    // Slot and valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= SLOT_MAGIC;
            valid_reg <= 1'b0;
        end else begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the request being acknowledged
    always_ff @(posedge aclk) begin
        req_reg <= req_next;
    end

    // Step through the reply; take the next request as the last byte leaves
    always_comb begin
        load       = !q_status.empty &&
                     (!valid_reg || (m_tready && slot_reg == SLOT_ZERO));
        slot_next  = slot_reg;
        valid_next = valid_reg;
        req_next   = req_reg;
        if (valid_reg && m_tready) begin
            case (slot_reg)
                SLOT_MAGIC: slot_next = SLOT_CODE;
                SLOT_CODE:  slot_next = SLOT_ZERO;
                default:    valid_next = 1'b0;
            endcase
        end
        if (load) begin
            valid_next = 1'b1;
            slot_next  = SLOT_MAGIC;
            req_next   = head_req;
        end
    end

    // Select the byte for the current slot
    always_comb begin
        case (slot_reg)
            SLOT_MAGIC: tx_byte = magic_byte;
            SLOT_CODE:  tx_byte = ack_code;
            default:    tx_byte = 8'h00;
        endcase
    end

    assign pop      = load;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {req_reg.command, tx_byte};
    assign m_tlast  = (slot_reg == SLOT_ZERO);
    assign m_tuser  = req_reg.set_all;

endmodule

// ===== hdl/framed_command_receiver.sv =====
// Framed command receiver: deframes received bytes and acknowledges frames.
// Usage:
//   s_ channel carries one received byte per transaction, with the power
//   flag in s_tuser; bytes with the flag low are dropped. A frame is the
//   magic byte, command, length L, L-1 data bytes and a checksum equal to
//   the XOR of the data bytes masked to 7 bits. A magic byte always
//   restarts a frame.
//   m_ channel returns three transactions per accepted frame: magic byte,
//   ack code, zero (tlast on the zero), each with the frame's command and
//   set-all flag.
//   cfg_ channel writes magic (0), set-all code (1) and ack code (2);
//   write only while the block is idle.
// Throughput: one input byte per cycle while the request queue is not full.
//   The first ack byte of a frame appears once its request is written to
//   the queue and then loaded into the ack sender register; the three ack
//   bytes then go out one per cycle while m_tready is high.
// Stalls: a two-entry request queue separates parser and ack sender;
//   s_tready drops only while that queue is full.
// Reset: aresetn low clears the parser to idle, empties the queue and
//   restores the register reset values (magic 0xAA, codes 0).
module framed_command_receiver
    import fcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] powered
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] tx_byte, [15:8] command
    output logic        m_tlast,
    output logic        m_tuser,   // [0] set_all_request
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0] magic_reg;
    logic [7:0] set_all_reg;
    logic [7:0] ack_reg;
    logic       push;
    logic       pop;
    ack_req_t   push_req;
    ack_req_t   head_req;
    q_status_t  q_status;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg   <= MAGIC_RESET;
            set_all_reg <= SET_ALL_RESET;
            ack_reg     <= ACK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MAGIC:   magic_reg   <= cfg_data;
                CFG_SET_ALL: set_all_reg <= cfg_data;
                CFG_ACK:     ack_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign s_tready = !q_status.full;

    fcr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_tvalid && s_tready),
        .rx_byte      (s_tdata),
        .powered      (s_tuser),
        .magic_byte   (magic_reg),
        .set_all_code (set_all_reg),
        .push         (push),
        .push_req     (push_req)
    );

    fcr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head_req (head_req),
        .status   (q_status)
    );

    fcr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_req   (head_req),
        .q_status   (q_status),
        .pop        (pop),
        .magic_byte (magic_reg),
        .ack_code   (ack_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== hdl/fcr_checker.sv =====
// Port-level checks for the framed command receiver, bound to the top level.
// Depends on the top level's port list only.
module fcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Stalled transaction holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Final ack byte is zero
    a_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
        else $error("last ack byte not zero");

    // Within a reply the next byte follows at once with the same command
    a_reply_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && $stable(m_tdata[15:8]) && $stable(m_tuser))
        else $error("reply broken or command changed");

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for framed_command_receiver: streams received bytes in, predicts
// the acknowledge bytes of every accepted frame and checks them in order.
// Depends on hdl/fcr_pkg.sv and hdl/framed_command_receiver.sv.
module testbench;
    import fcr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    // One received byte with its power flag and the idle cycles in front of it
    typedef struct packed {
        logic [7:0] rx;
        logic       pw;
        logic [3:0] gap;
    } rx_item_t;

    // One acknowledge byte as it leaves the block
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic [7:0] command;
        logic       set_all;
    } ack_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_MAGIC;
    logic [7:0]  cfg_data = 8'h00;

    framed_command_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Register shadow and parser state of the predictor
    logic [7:0] magic_reg   = MAGIC_RESET;
    logic [7:0] set_all_reg = SET_ALL_RESET;
    logic [7:0] ack_reg     = ACK_RESET;
    phase_t     frame_phase = PH_IDLE;
    logic [8:0] frame_pos   = '0;
    logic [7:0] frame_len   = '0;
    logic [7:0] frame_cmd   = '0;
    logic [7:0] data_xor    = '0;

    rx_item_t pending_q[$];
    ack_t     ack_expect_q[$];

    int cycle_count    = 0;
    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int powered_bytes  = 0;
    int acks_checked   = 0;
    int frames_acked   = 0;
    int set_all_acks   = 0;
    int mismatch_count = 0;

    bit s_fire = 1'b0;
    bit m_fire = 1'b0;

    // Sender and receiver idling controls
    bit tx_idle_allowed = 1'b0;
    bit tx_idle_on      = 1'b0;
    bit rx_idle_allowed = 1'b0;
    bit rx_idle_on      = 1'b0;
    int hold_req_count  = 0;
    int hold_req_seen   = 0;
    int hold_left       = 0;
    int rx_stall_left   = 0;

    bit       staged = 1'b0;
    int       gap_left = 0;
    rx_item_t next_item;

    // Queue the three acknowledge bytes of an accepted frame and return to idle
    function automatic void queue_ack();
        logic all_flag;
        all_flag = (frame_cmd == set_all_reg);
        ack_expect_q.push_back('{magic_reg, 1'b0, frame_cmd, all_flag});
        ack_expect_q.push_back('{ack_reg, 1'b0, frame_cmd, all_flag});
        ack_expect_q.push_back('{8'h00, 1'b1, frame_cmd, all_flag});
        frame_phase = PH_IDLE;
        frame_pos = '0;
    endfunction

    // Advance the deframer by one received byte
    function automatic void parse_byte(logic [7:0] rx, logic pw);
        if (!pw)
            return;
        if (rx == magic_reg) begin
            frame_phase = PH_HEADER;
            frame_pos = 9'd1;
            data_xor = '0;
        end else if (frame_phase == PH_HEADER) begin
            if (frame_pos == 9'd1) begin
                frame_cmd = rx;
                frame_pos = 9'd2;
            end else begin
                frame_len = rx;
                if (rx == 8'h00) begin
                    queue_ack();
                end else begin
                    frame_phase = PH_DATA;
                    frame_pos = 9'd3;
                    data_xor = '0;
                end
            end
        end else if (frame_phase == PH_DATA) begin
            if (int'(frame_pos) < int'(frame_len) + 2) begin
                data_xor ^= rx;
                if (frame_pos != POS_MAX)
                    frame_pos++;
            end else if ((data_xor & CHECK_MASK) == rx) begin
                queue_ack();
            end else begin
                frame_phase = PH_IDLE;
                frame_pos = '0;
            end
        end
    endfunction

    function automatic int draw_stall(bit on);
        return on ? $urandom_range(0, 10) : 0;
    endfunction

    function automatic logic [7:0] not_magic(logic [7:0] b);
        return (b == magic_reg) ? (b ^ 8'h01) : b;
    endfunction

    task automatic push_byte(input logic [7:0] rx, input logic pw);
        rx_item_t it;
        it.rx = rx;
        it.pw = pw;
        it.gap = tx_idle_on ? 4'($urandom_range(0, 10)) : 4'd0;
        pending_q.push_back(it);
        bytes_queued++;
        if (pw)
            powered_bytes++;
    endtask

    // Queue one frame: mostly well formed, some with a bad checksum, some cut
    // short, some plain noise; powered-off bytes are sprinkled in between
    task automatic queue_random_frame();
        logic [7:0] frame_q[$];
        logic [7:0] cmd;
        logic [7:0] len_b;
        logic [7:0] b;
        logic [7:0] x;
        int kind;
        int keep;
        kind = $urandom_range(0, 9);
        if (tx_idle_allowed && $urandom_range(0, 7) == 0)
            tx_idle_on = !tx_idle_on;
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end else begin
            cmd = ($urandom_range(0, 3) == 0) ? set_all_reg : 8'($urandom);
            // Mostly short lengths, now and then a longer frame
            len_b = not_magic(($urandom_range(0, 39) == 0) ? 8'($urandom_range(7, 40))
                                                           : 8'($urandom_range(0, 6)));
            x = 8'h00;
            frame_q = '{magic_reg, not_magic(cmd), len_b};
            for (int i = 1; i < int'(len_b); i++) begin
                b = not_magic(8'($urandom));
                x ^= b;
                frame_q.push_back(b);
            end
            if (len_b != 8'h00) begin
                b = x & CHECK_MASK;
                if (kind == 1)
                    b ^= 8'(1 << $urandom_range(0, 7));
                frame_q.push_back(b);
            end
            keep = (kind == 2) ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
            for (int i = 0; i < keep; i++) begin
                if ($urandom_range(0, 15) == 0)
                    push_byte(8'($urandom), 1'b0);
                push_byte(frame_q[i], 1'b1);
            end
        end
    endtask

    // Write one register; the block is idle whenever this is called
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MAGIC:   magic_reg = val;
            CFG_SET_ALL: set_all_reg = val;
            CFG_ACK:     ack_reg = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every queued byte is taken and every acknowledge has come back
    task automatic wait_quiet();
        while (bytes_accepted != bytes_queued || ack_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Input driver: present queued bytes with their gaps, hold until accepted
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // hold the current transaction
        end else begin
            if (!staged && pending_q.size() != 0) begin
                next_item = pending_q.pop_front();
                staged = 1'b1;
                gap_left = next_item.gap;
            end
            if (staged && gap_left == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.rx;
                s_tuser  <= next_item.pw;
                staged = 1'b0;
            end else begin
                s_tvalid <= 1'b0;
                if (staged)
                    gap_left--;
            end
        end
    end

    // Result receiver: random stalls, calm stretches and the long hold-off
    always @(negedge aclk) begin
        if (hold_req_seen != hold_req_count) begin
            hold_req_seen = hold_req_count;
            hold_left = HOLD_CYCLES;
        end
        if (m_fire)
            rx_stall_left = draw_stall(rx_idle_allowed && rx_idle_on);
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        if (rx_idle_allowed && $urandom_range(0, 63) == 0)
            rx_idle_on = !rx_idle_on;
    end

    // Monitor: predict on each accepted byte, check each acknowledge byte
    always @(posedge aclk) begin
        ack_t got;
        ack_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d acknowledge bytes outstanding",
                     cycle_count, ack_expect_q.size());
            $display("framed_command_receiver regression: fail");
            $finish;
        end else begin
            s_fire = aresetn && s_tvalid && s_tready;
            m_fire = aresetn && m_tvalid && m_tready;
            if (s_fire) begin
                bytes_accepted++;
                parse_byte(s_tdata, s_tuser);
            end
            if (m_fire) begin
                got = '{m_tdata[7:0], m_tlast, m_tdata[15:8], m_tuser};
                acks_checked++;
                if (ack_expect_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected ack byte: tx=%02h last=%0b cmd=%02h all=%0b",
                                 got.tx_byte, got.last, got.command, got.set_all);
                end else begin
                    want = ack_expect_q.pop_front();
                    if (got.tx_byte !== want.tx_byte || got.last !== want.last ||
                        got.command !== want.command || got.set_all !== want.set_all) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("ack mismatch: expected tx=%02h last=%0b cmd=%02h all=%0b, %s",
                                     want.tx_byte, want.last, want.command, want.set_all,
                                     $sformatf("got tx=%02h last=%0b cmd=%02h all=%0b",
                                               got.tx_byte, got.last, got.command,
                                               got.set_all));
                    end
                    if (want.last) begin
                        frames_acked++;
                        if (want.set_all)
                            set_all_acks++;
                    end
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        logic [7:0] dir_q[$];
        int target;
        int drain;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames under the reset magic byte 0xAA: zero length with
        // set-all command, length one, two data bytes, full 8-bit checksum
        // mismatch, magic in place of the length, stray bytes while idle
        push_byte(8'hAA, 1'b0);
        dir_q = '{8'h00, 8'hFF,
                  8'hAA, 8'h00, 8'h00,
                  8'hAA, 8'hFF, 8'h01, 8'h00,
                  8'hAA, 8'h12, 8'h03, 8'h55, 8'h80, 8'h55,
                  8'hAA, 8'h34, 8'h02, 8'h7F, 8'hFF,
                  8'hAA, 8'h21, 8'hAA, 8'h22, 8'h00,
                  8'h00};
        foreach (dir_q[i])
            push_byte(dir_q[i], 1'b1);
        wait_quiet();

        // Extreme register values, random traffic with idling on both sides
        write_reg(CFG_MAGIC, 8'h00);
        write_reg(CFG_SET_ALL, 8'hFF);
        write_reg(CFG_ACK, 8'hFF);
        tx_idle_allowed = 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_allowed = 1'b1;
        target = powered_bytes + 120;
        while (powered_bytes < target)
            queue_random_frame();
        wait_quiet();

        // Back-to-back short frames against a long receiver hold-off
        write_reg(CFG_MAGIC, 8'hFF);
        write_reg(CFG_SET_ALL, 8'($urandom));
        write_reg(CFG_ACK, 8'h5A);
        tx_idle_allowed = 1'b0;
        tx_idle_on = 1'b0;
        rx_idle_allowed = 1'b0;
        hold_req_count++;
        repeat (12) begin
            push_byte(magic_reg, 1'b1);
            push_byte(($urandom_range(0, 1) == 0) ? set_all_reg : 8'($urandom_range(0, 254)),
                      1'b1);
            push_byte(8'h00, 1'b1);
        end
        wait_quiet();

        // Random register values, random traffic with calm stretches
        write_reg(CFG_MAGIC, 8'($urandom));
        write_reg(CFG_SET_ALL, 8'($urandom));
        write_reg(CFG_ACK, 8'($urandom));
        tx_idle_allowed = 1'b1;
        rx_idle_allowed = 1'b1;
        target = powered_bytes + 130;
        while (powered_bytes < target)
            queue_random_frame();

        // Drain: everything accepted, then all acknowledges back, then settle
        while (bytes_accepted != bytes_queued)
            @(posedge aclk);
        drain = 0;
        while (ack_expect_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (ack_expect_q.size() != 0) begin
            $display("%0d expected ack bytes never arrived", ack_expect_q.size());
            mismatch_count += ack_expect_q.size();
        end

        $display("covered %0d input bytes, %0d ack bytes checked, %0d frames acknowledged",
                 bytes_accepted, acks_checked, frames_acked);
        $display("%0d set-all acknowledges, %0d mismatches, 4 register settings",
                 set_all_acks, mismatch_count);
        if (mismatch_count == 0) begin
            $display("framed_command_receiver regression: pass");
        end else begin
            $display("framed_command_receiver regression: fail");
        end
        $finish;
    end

endmodule
